>>> hw/rtl/spwq_pkg.sv
// Package with shared types and constants of the semaphore priority wait queue.
package spwq_pkg;

  localparam int COUNT_W = 16;
  localparam int MODE_W = 3;
  localparam int MAX_WAITERS_DEF = 16;
  localparam int ID_BITS_DEF = 8;
  localparam int PRIO_BITS_DEF = 3;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [MODE_W-1:0] {
    MODE_CNT_WAIT = 3'd0,
    MODE_CNT_SIGNAL = 3'd1,
    MODE_BIN_WAIT = 3'd2,
    MODE_BIN_SIGNAL = 3'd3,
    MODE_REINIT = 3'd4
  } mode_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
  } ctl_cmd_t;

endpackage

>>> hw/rtl/semaphore_priority_wait_queue.sv
// Top level of the semaphore with a priority-ordered wait queue.
// An accepted beat is captured, then executed once no pending result is held back by out_stall;
// its result beat is registered and becomes valid after that execution.
// A new beat is not accepted until the previous one has been executed; in_stall is high meanwhile.
// The queue is a sorted shift register that inserts or pops in the execute cycle.
// Synchronous active-low reset clears the count, the waiter total and initial_count; the queue
// entries themselves are not cleared.
module semaphore_priority_wait_queue #(
  parameter int MAX_WAITERS = spwq_pkg::MAX_WAITERS_DEF,
  parameter int ID_BITS = spwq_pkg::ID_BITS_DEF,
  parameter int PRIO_BITS = spwq_pkg::PRIO_BITS_DEF,
  localparam int CNT_W = $clog2(MAX_WAITERS + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [spwq_pkg::COUNT_W-1:0]   cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [spwq_pkg::MODE_W-1:0]    in_mode,
  input  logic [ID_BITS-1:0]             in_thread_id,
  input  logic [PRIO_BITS-1:0]           in_thread_priority,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_must_block,
  output logic                           out_refused,
  output logic                           out_woken_valid,
  output logic [ID_BITS-1:0]             out_woken_thread,
  output logic [spwq_pkg::COUNT_W-1:0]   out_count_now,
  output logic [CNT_W-1:0]               out_waiters_now
);

  spwq_pkg::ctl_cmd_t cmd;

  spwq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  spwq_datapath #(
    .MAX_WAITERS (MAX_WAITERS),
    .ID_BITS     (ID_BITS),
    .PRIO_BITS   (PRIO_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_mode            (in_mode),
    .in_thread_id       (in_thread_id),
    .in_thread_priority (in_thread_priority),
    .out_must_block     (out_must_block),
    .out_refused        (out_refused),
    .out_woken_valid    (out_woken_valid),
    .out_woken_thread   (out_woken_thread),
    .out_count_now      (out_count_now),
    .out_waiters_now    (out_waiters_now)
  );

endmodule

>>> hw/rtl/spwq_ctrl.sv
// Controller state machine that sequences capture, execution and result handoff.
module spwq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output spwq_pkg::ctl_cmd_t  cmd
);

  spwq_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spwq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r;
    in_stall = 1'b1;
    cmd = '0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      spwq_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = spwq_pkg::ST_EXEC;
        end
      end
      spwq_pkg::ST_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          cmd.exec = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = spwq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = spwq_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/spwq_datapath.sv
// Datapath with the semaphore count, the sorted shift-register wait queue and the result register.
module spwq_datapath #(
  parameter int MAX_WAITERS = spwq_pkg::MAX_WAITERS_DEF,
  parameter int ID_BITS = spwq_pkg::ID_BITS_DEF,
  parameter int PRIO_BITS = spwq_pkg::PRIO_BITS_DEF,
  localparam int CNT_W = $clog2(MAX_WAITERS + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  spwq_pkg::ctl_cmd_t             cmd,
  input  logic                           cfg_wr_en,
  input  logic [spwq_pkg::COUNT_W-1:0]   cfg_wr_data,
  input  logic [spwq_pkg::MODE_W-1:0]    in_mode,
  input  logic [ID_BITS-1:0]             in_thread_id,
  input  logic [PRIO_BITS-1:0]           in_thread_priority,
  output logic                           out_must_block,
  output logic                           out_refused,
  output logic                           out_woken_valid,
  output logic [ID_BITS-1:0]             out_woken_thread,
  output logic [spwq_pkg::COUNT_W-1:0]   out_count_now,
  output logic [CNT_W-1:0]               out_waiters_now
);

  logic [spwq_pkg::COUNT_W-1:0] init_r;
  logic [spwq_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  spwq_pkg::mode_t mode_r;
  logic [ID_BITS-1:0] id_r;
  logic [PRIO_BITS-1:0] prio_r;

  logic [ID_BITS-1:0] qid_r [MAX_WAITERS];
  logic [PRIO_BITS-1:0] qprio_r [MAX_WAITERS];
  logic [MAX_WAITERS-1:0] stay;

  logic is_wait, is_signal, cnt_zero, q_full, q_empty, do_insert, do_pop, refuse;

  logic must_block_r, refused_r, woken_valid_r;
  logic [ID_BITS-1:0] woken_thread_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= '0;
    end else if (cfg_wr_en) begin
      init_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= spwq_pkg::mode_t'(in_mode);
      id_r <= in_thread_id;
      prio_r <= in_thread_priority;
    end
  end

  always_comb begin
    is_wait = 1'b0;
    is_signal = 1'b0;
    case (mode_r)
      spwq_pkg::MODE_CNT_WAIT, spwq_pkg::MODE_BIN_WAIT: is_wait = 1'b1;
      spwq_pkg::MODE_CNT_SIGNAL, spwq_pkg::MODE_BIN_SIGNAL: is_signal = 1'b1;
      default: begin
        is_wait = 1'b0;
        is_signal = 1'b0;
      end
    endcase
  end

  assign cnt_zero = (count_r == '0);
  assign q_full = (total_r == CNT_W'(MAX_WAITERS));
  assign q_empty = (total_r == '0);
  assign do_insert = is_wait && cnt_zero && !q_full;
  assign refuse = is_wait && cnt_zero && q_full;
  assign do_pop = is_signal && !q_empty;

  always_comb begin
    count_nxt = count_r;
    total_nxt = total_r;
    unique case (mode_r)
      spwq_pkg::MODE_CNT_WAIT: begin
        if (!cnt_zero) begin
          count_nxt = count_r - 1'b1;
        end
      end
      spwq_pkg::MODE_BIN_WAIT: begin
        if (!cnt_zero) begin
          count_nxt = '0;
        end
      end
      spwq_pkg::MODE_CNT_SIGNAL: begin
        if (q_empty && count_r != spwq_pkg::COUNT_MAX) begin
          count_nxt = count_r + 1'b1;
        end
      end
      spwq_pkg::MODE_BIN_SIGNAL: begin
        count_nxt = q_empty ? spwq_pkg::COUNT_W'(1) : '0;
      end
      spwq_pkg::MODE_REINIT: begin
        count_nxt = init_r;
        total_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    if (do_insert) begin
      total_nxt = total_r + 1'b1;
    end else if (do_pop) begin
      total_nxt = total_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      total_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
      total_r <= total_nxt;
    end
  end

  // A cell stays in place on insert when it holds a waiter of equal or better priority.
  for (genvar i = 0; i < MAX_WAITERS; i++) begin : g_cell
    assign stay[i] = (CNT_W'(i) < total_r) && (qprio_r[i] <= prio_r);

    always_ff @(posedge clk) begin
      if (cmd.exec && do_insert) begin
        if (i == 0) begin
          if (!stay[0]) begin
            qid_r[i] <= id_r;
            qprio_r[i] <= prio_r;
          end
        end else if (!stay[(i == 0) ? 0 : i - 1]) begin
          qid_r[i] <= qid_r[(i == 0) ? 0 : i - 1];
          qprio_r[i] <= qprio_r[(i == 0) ? 0 : i - 1];
        end else if (!stay[i]) begin
          qid_r[i] <= id_r;
          qprio_r[i] <= prio_r;
        end
      end else if (cmd.exec && do_pop && i < MAX_WAITERS - 1) begin
        qid_r[i] <= qid_r[(i < MAX_WAITERS - 1) ? i + 1 : i];
        qprio_r[i] <= qprio_r[(i < MAX_WAITERS - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      must_block_r <= do_insert;
      refused_r <= refuse;
      woken_valid_r <= do_pop;
      woken_thread_r <= do_pop ? qid_r[0] : '0;
    end
  end

  logic [spwq_pkg::COUNT_W-1:0] count_out_r;
  logic [CNT_W-1:0] total_out_r;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      count_out_r <= count_nxt;
      total_out_r <= total_nxt;
    end
  end

  assign out_must_block = must_block_r;
  assign out_refused = refused_r;
  assign out_woken_valid = woken_valid_r;
  assign out_woken_thread = woken_thread_r;
  assign out_count_now = count_out_r;
  assign out_waiters_now = total_out_r;

endmodule
